// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

   // default build of the frame row
   localparam int FRAMES_DEF     = 8;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths at the ports
   localparam int REQ_PAGE_BITS   = 16;
   localparam int RSP_INDEX_BITS  = 3;
   localparam int RSP_PAGE_BITS   = 16;
   localparam int FAULT_BITS      = 16;
   localparam int CSR_BITS        = 4;

   localparam logic [CSR_BITS-1:0]   FRAMES_IN_USE_RESET = 4'd8;
   localparam logic [FAULT_BITS-1:0] FAULT_MAX           = 16'hFFFF;

endpackage

// ===== sv/lfu_cell.sv =====
`timescale 1ns / 1ps

module lfu_cell #(
   parameter int INDEX      = 0,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16,
   parameter int IW         = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     active,
   input  logic                     clr,
   // scan record from the left neighbor
   input  logic [1+PAGE_BITS+1+IW+1+IW+COUNT_BITS+IW+PAGE_BITS-1:0] rec_in,
   // scan record handed to the right neighbor
   output logic [1+PAGE_BITS+1+IW+1+IW+COUNT_BITS+IW+PAGE_BITS-1:0] rec_out,
   // update broadcast from the decision logic
   input  logic [1+1+IW+PAGE_BITS-1:0] upd_in
);

   typedef struct packed {
      logic                  vld;
      logic [PAGE_BITS-1:0]  page;
      logic                  found;
      logic [IW-1:0]         hit_idx;
      logic                  empty;
      logic [IW-1:0]         empty_idx;
      logic [COUNT_BITS-1:0] min_cnt;
      logic [IW-1:0]         min_idx;
      logic [PAGE_BITS-1:0]  min_page;
   } rec_type;

   typedef struct packed {
      logic                 en;
      logic                 inc;
      logic [IW-1:0]        slot;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

   localparam logic [IW-1:0]         MY_IDX    = IW'(INDEX);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   rec_type rec_i;
   rec_type rec_in_w;
   rec_type rec_ff;
   upd_type upd;

   logic [PAGE_BITS-1:0]  page_ff;
   logic [PAGE_BITS-1:0]  page_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   assign rec_i   = rec_in;
   assign upd     = upd_in;
   assign rec_out = rec_ff;

   // fold this frame into the running search record
   always_comb begin
      rec_in_w = rec_i;
      if (active) begin
         if (!rec_i.found && valid_ff && page_ff == rec_i.page) begin
            rec_in_w.found   = 1'b1;
            rec_in_w.hit_idx = MY_IDX;
         end
         if (!rec_i.empty && !valid_ff) begin
            rec_in_w.empty     = 1'b1;
            rec_in_w.empty_idx = MY_IDX;
         end
         // first frame always seeds the minimum, later ones only when strictly smaller
         if (INDEX == 0 || count_ff < rec_i.min_cnt) begin
            rec_in_w.min_cnt  = count_ff;
            rec_in_w.min_idx  = MY_IDX;
            rec_in_w.min_page = page_ff;
         end
      end
   end

   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      if (clr) begin
         page_in  = '0;
         valid_in = 1'b0;
         count_in = '0;
      end else if (upd.en && upd.slot == MY_IDX) begin
         if (upd.inc) begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            page_in  = upd.page;
            valid_in = 1'b1;
            count_in = COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff   <= '0;
         page_ff  <= '0;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         rec_ff   <= rec_in_w;
         page_ff  <= page_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/lfu_page_replacement.sv =====
`timescale 1ns / 1ps

// channel   | ports                                   | transfer when
// ----------+-----------------------------------------+-----------------------
// request   | start, busy, req_page, req_start_new    | start && !busy
// response  | rsp_valid, rsp_hit .. rsp_fault_total   | rsp_valid (one cycle)
// csr       | csr_valid, csr_ready, csr_data          | csr_valid && csr_ready
//
// in one reference the search record walks the row of
// frame cells one cell per cycle, then the chosen cell is updated and the
// response is driven. busy drops in the response cycle, so start may follow.
// reset empties every frame, clears the fault counter and sets frames_in_use
// to 8. the response cannot be held off; it is valid for exactly one cycle.

module lfu_page_replacement #(
   parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
   parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lfu_pkg::REQ_PAGE_BITS-1:0]  req_page,
   input  logic                               req_start_new,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lfu_pkg::RSP_INDEX_BITS-1:0] rsp_frame_index,
   output logic                               rsp_evicted_valid,
   output logic [lfu_pkg::RSP_PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [lfu_pkg::FAULT_BITS-1:0]     rsp_fault_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfu_pkg::CSR_BITS-1:0]       csr_data
);

   import lfu_pkg::*;

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   typedef struct packed {
      logic                  vld;
      logic [PAGE_BITS-1:0]  page;
      logic                  found;
      logic [IW-1:0]         hit_idx;
      logic                  empty;
      logic [IW-1:0]         empty_idx;
      logic [COUNT_BITS-1:0] min_cnt;
      logic [IW-1:0]         min_idx;
      logic [PAGE_BITS-1:0]  min_page;
   } rec_type;

   typedef struct packed {
      logic                 en;
      logic                 inc;
      logic [IW-1:0]        slot;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

   rec_type rec [FRAMES+1];
   rec_type head_ff;
   rec_type head_in;
   rec_type tail;
   upd_type upd;

   logic                  accept;
   logic                  clr;
   logic [FRAMES-1:0]     active;
   logic [PAGE_BITS+REQ_PAGE_BITS-1:0] page_ext;
   logic [PAGE_BITS+RSP_PAGE_BITS-1:0] evict_ext;
   logic [IW+RSP_INDEX_BITS-1:0]       slot_ext;

   logic                      busy_ff;
   logic                      busy_in;
   logic [CSR_BITS-1:0]       frames_ff;
   logic [CSR_BITS-1:0]       frames_in;
   logic [FAULT_BITS-1:0]     fault_ff;
   logic [FAULT_BITS-1:0]     fault_in;

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic                      rsp_hit_in;
   logic [RSP_INDEX_BITS-1:0] rsp_index_ff;
   logic [RSP_INDEX_BITS-1:0] rsp_index_in;
   logic                      rsp_ev_valid_ff;
   logic                      rsp_ev_valid_in;
   logic [RSP_PAGE_BITS-1:0]  rsp_ev_page_ff;
   logic [RSP_PAGE_BITS-1:0]  rsp_ev_page_in;

   assign accept    = start && !busy_ff;
   assign clr       = accept && req_start_new;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   assign page_ext = {{PAGE_BITS{1'b0}}, req_page};

   always_comb begin
      head_in          = '0;
      head_in.vld      = accept;
      head_in.page     = page_ext[PAGE_BITS-1:0];
      head_in.min_cnt  = '1;
   end

   // a zero count still manages frame 0; counts above FRAMES reach every cell
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         if (frames_ff == '0) begin
            active[i] = (i == 0);
         end else begin
            active[i] = (i < int'(frames_ff));
         end
      end
   end

   assign rec[0] = head_ff;
   assign tail   = rec[FRAMES];

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lfu_cell #(
         .INDEX      (g),
         .PAGE_BITS  (PAGE_BITS),
         .COUNT_BITS (COUNT_BITS),
         .IW         (IW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active[g]),
         .clr     (clr),
         .rec_in  (rec[g]),
         .rec_out (rec[g+1]),
         .upd_in  (upd)
      );
   end

   // decision once the record leaves the last cell
   always_comb begin
      upd             = '0;
      upd.page        = tail.page;
      rsp_hit_in      = 1'b0;
      rsp_ev_valid_in = 1'b0;
      evict_ext       = '0;
      fault_in        = fault_ff;
      if (tail.vld) begin
         upd.en = 1'b1;
         if (tail.found) begin
            upd.inc    = 1'b1;
            upd.slot   = tail.hit_idx;
            rsp_hit_in = 1'b1;
         end else begin
            if (tail.empty) begin
               upd.slot = tail.empty_idx;
            end else begin
               upd.slot        = tail.min_idx;
               rsp_ev_valid_in = 1'b1;
               evict_ext       = {{RSP_PAGE_BITS{1'b0}}, tail.min_page};
            end
            if (fault_ff != FAULT_MAX) begin
               fault_in = fault_ff + 1'b1;
            end
         end
      end
      if (clr) begin
         fault_in = '0;
      end
   end

   assign slot_ext       = {{RSP_INDEX_BITS{1'b0}}, upd.slot};
   assign rsp_index_in   = slot_ext[RSP_INDEX_BITS-1:0];
   assign rsp_ev_page_in = evict_ext[RSP_PAGE_BITS-1:0];

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.vld) begin
         busy_in = 1'b0;
      end
   end

   assign frames_in = (csr_valid && csr_ready) ? csr_data : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         busy_ff      <= 1'b0;
         frames_ff    <= FRAMES_IN_USE_RESET;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         busy_ff      <= busy_in;
         frames_ff    <= frames_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= tail.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.vld) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_ev_valid_ff <= rsp_ev_valid_in;
         rsp_ev_page_ff  <= rsp_ev_page_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = fault_ff;

endmodule
